// ===== sv/f32a_pkg.sv =====
// Shared types and constants for the single-precision same-sign adder.
// Used by f32a_round and float32_same_sign_adder_unit.
package f32a_pkg;

  localparam logic [31:0] QnanPos = 32'h7fc0_0000;
  localparam logic [31:0] QnanNeg = 32'hffc0_0000;
  localparam logic [31:0] InfPos  = 32'h7f80_0000;
  localparam logic [31:0] InfNeg  = 32'hff80_0000;
  localparam logic [31:0] ZeroNeg = 32'h8000_0000;
  localparam logic [7:0]  ExpMax  = 8'hff;
  localparam int unsigned SigW    = 25;
  localparam logic [4:0]  ShMax   = 5'd26;

  typedef struct packed {
    logic            special;
    logic [31:0]     spec_val;
    logic            sign;
    logic [7:0]      exp;
    logic [SigW-1:0] big;
    logic [SigW-1:0] small_sig;
    logic [4:0]      shamt;
  } dec_t;

  typedef struct packed {
    logic            special;
    logic [31:0]     spec_val;
    logic            sign;
    logic [7:0]      exp;
    logic [SigW-1:0] big;
    logic [SigW-1:0] small_sh;
    logic            sticky;
  } aln_t;

  typedef struct packed {
    logic            special;
    logic [31:0]     spec_val;
    logic            sign;
    logic [8:0]      exp;
    logic [SigW-1:0] sum;
    logic            sticky;
  } add_t;

endpackage

// ===== sv/f32a_round.sv =====
// Round-to-nearest-even and final packing of the adder result.
// Depends on f32a_pkg.
module f32a_round (
  input  f32a_pkg::add_t s_i,
  output logic [31:0]    res_o
);
  import f32a_pkg::*;

  logic            rnd;
  logic [SigW:0]   sum_r;
  logic [8:0]      exp_f;
  logic [22:0]     frac;

  always_comb begin
    rnd   = s_i.sum[0] & (s_i.sum[1] | s_i.sticky);
    sum_r = {1'b0, s_i.sum} + (rnd ? (SigW+1)'(2) : '0);
    exp_f = s_i.exp;
    frac  = sum_r[23:1];
    if (s_i.exp == {1'b0, ExpMax}) begin
      frac = '0;
    end else if (sum_r[SigW]) begin
      exp_f = s_i.exp + 9'd1;
      frac  = sum_r[24:2];
    end
    res_o = s_i.special ? s_i.spec_val : {s_i.sign, exp_f[7:0], frac};
  end

endmodule

// ===== sv/float32_same_sign_adder_unit.sv =====
// Top level of the single-precision same-sign adder.
// Depends on f32a_pkg and f32a_round.
//
// Four-stage pipeline: decode and exponent compare, alignment shift with
// sticky, significand add with carry renormalization, rounding into the
// output register. A word pair is accepted every cycle while the output
// is not stalled; a stall holds each full stage in place, while an empty
// stage still takes the data from the stage before it.
module float32_same_sign_adder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o
);
  import f32a_pkg::*;

  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4;
  dec_t s1_d, s1_q;
  aln_t s2_d, s2_q;
  add_t s3_d, s3_q;
  logic [31:0] res_d, res_q;

  assign rdy4 = !vo_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = vo_q;
  assign sum_bits_o  = res_q;

  logic        sa, sb;
  logic [7:0]  ea, eb, ed;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_big;

  always_comb begin
    sa = operand_a_i[31];
    sb = operand_b_i[31];
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    nan_a  = (ea == ExpMax) && (fa != '0);
    nan_b  = (eb == ExpMax) && (fb != '0);
    inf_a  = (ea == ExpMax) && (fa == '0);
    inf_b  = (eb == ExpMax) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    a_big  = ea > eb;
    ed     = a_big ? ea - eb : eb - ea;

    s1_d.special  = 1'b1;
    s1_d.spec_val = '0;
    if (nan_a || nan_b) begin
      s1_d.spec_val = QnanPos;
    end else if (inf_a && inf_b) begin
      s1_d.spec_val = (sa != sb) ? QnanNeg : (sa ? InfNeg : InfPos);
    end else if (inf_a) begin
      s1_d.spec_val = sa ? InfNeg : InfPos;
    end else if (inf_b) begin
      s1_d.spec_val = sb ? InfNeg : InfPos;
    end else if (zero_a && zero_b && sa && sb) begin
      s1_d.spec_val = ZeroNeg;
    end else if (zero_a) begin
      s1_d.spec_val = operand_b_i;
    end else if (zero_b) begin
      s1_d.spec_val = operand_a_i;
    end else if (sa != sb) begin
      s1_d.spec_val = '0;
    end else begin
      s1_d.special = 1'b0;
    end
    s1_d.sign      = sa;
    s1_d.exp       = a_big ? ea : eb;
    s1_d.big       = {1'b1, (a_big ? fa : fb), 1'b0};
    s1_d.small_sig = {1'b1, (a_big ? fb : fa), 1'b0};
    s1_d.shamt     = (ed >= 8'(ShMax)) ? ShMax : ed[4:0];
  end

  always_comb begin
    s2_d.special  = s1_q.special;
    s2_d.spec_val = s1_q.spec_val;
    s2_d.sign     = s1_q.sign;
    s2_d.exp      = s1_q.exp;
    s2_d.big      = s1_q.big;
    s2_d.small_sh = s1_q.small_sig >> s1_q.shamt;
    s2_d.sticky   = |(s1_q.small_sig & ~({SigW{1'b1}} << s1_q.shamt));
  end

  logic [SigW:0] sum_w;

  always_comb begin
    sum_w         = {1'b0, s2_q.big} + {1'b0, s2_q.small_sh};
    s3_d.special  = s2_q.special;
    s3_d.spec_val = s2_q.spec_val;
    s3_d.sign     = s2_q.sign;
    if (sum_w[SigW]) begin
      s3_d.exp    = {1'b0, s2_q.exp} + 9'd1;
      s3_d.sum    = sum_w[SigW:1];
      s3_d.sticky = s2_q.sticky | sum_w[0];
    end else begin
      s3_d.exp    = {1'b0, s2_q.exp};
      s3_d.sum    = sum_w[SigW-1:0];
      s3_d.sticky = s2_q.sticky;
    end
  end

  f32a_round u_round (
    .s_i   (s3_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q  <= s1_d;
    if (rdy2) s2_q  <= s2_d;
    if (rdy3) s3_q  <= s3_d;
    if (rdy4) res_q <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_nan_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operand_a_i[30:23] == ExpMax) && (operand_a_i[22:0] != '0))
    |=> (s1_q.special && s1_q.spec_val == QnanPos))
    else $error("nan operand not flagged");
  a_shamt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> s1_q.shamt <= ShMax)
    else $error("alignment shift exceeds cap");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !s3_q.special) |-> s3_q.sum[SigW-1])
    else $error("sum not normalized");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy3) |=> (v3_q && $stable(s3_q)))
    else $error("stalled stage changed");
`endif

endmodule
